>>> sv/gww_pkg.sv
// shared types, constants and payload structs for the greedy word wrap block
// no dependencies; every other file refers to it by scoped names
package gww_pkg;

	// sizes of the word store and the offset arithmetic
	localparam int WORD_DEPTH  = 62;
	localparam int OFFSET_BITS = 20;
	localparam int CP_BITS     = 21;
	localparam int ADV_BITS    = 12;
	localparam int LW_BITS     = 20;
	localparam int CNT_BITS    = $clog2(WORD_DEPTH + 1);
	localparam int SUM_BITS    = ((OFFSET_BITS > ADV_BITS) ? OFFSET_BITS : ADV_BITS) + 1;
	localparam int CMP_BITS    = (OFFSET_BITS > LW_BITS) ? OFFSET_BITS : LW_BITS;

	localparam logic [SUM_BITS-1:0] OFF_MAX =
		SUM_BITS'((64'd1 << OFFSET_BITS) - 64'd1);

	// command queue between front and back
	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// special characters
	localparam logic [CP_BITS-1:0] CH_NEWLINE = CP_BITS'(10);
	localparam logic [CP_BITS-1:0] CH_SPACE   = CP_BITS'(32);

	// input transfer
	typedef struct packed {
		logic [CP_BITS-1:0]  code_point;
		logic [ADV_BITS-1:0] advance;
		logic                end_of_text;
	} item_t;

	// result transfer
	typedef struct packed {
		logic [CP_BITS-1:0] out_code_point;
		logic               run_last;
		logic               word_too_long;
	} result_t;

	// one item's emission plan: leading space, held word, tail char, trailing space
	typedef struct packed {
		logic                sp_en;
		logic                sp_nl;
		logic [CNT_BITS-1:0] word_cnt;
		logic                tail_en;
		logic [CP_BITS-1:0]  tail_cp;
		logic                post_en;
		logic                forced;
	} cmd_t;

	// word store write port
	typedef struct packed {
		logic                en;
		logic [CNT_BITS-1:0] addr;
		logic [CP_BITS-1:0]  data;
	} wr_t;

	// back status seen by the front
	typedef struct packed {
		logic word_act;
		logic word_done;
	} bk_stat_t;

	// back sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_WORD,
		PH_TAIL,
		PH_POST
	} ph_t;

endpackage

>>> sv/gww_front.sv
// front part: accepts characters, keeps line offset and held word state, builds commands
// depends on gww_pkg
module gww_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [gww_pkg::LW_BITS-1:0] cfg_wr_data,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  gww_pkg::item_t            item,
	input  logic                      q_full,
	output logic                      q_push,
	output gww_pkg::cmd_t             q_cmd,
	output gww_pkg::wr_t              wr,
	input  gww_pkg::bk_stat_t         stat
);

	logic [gww_pkg::OFFSET_BITS-1:0] line_offset_q, word_width_q;
	logic [gww_pkg::OFFSET_BITS-1:0] offset_d, width_d, off_c, ww_c;
	logic [gww_pkg::CNT_BITS-1:0]    word_count_q, count_d;
	logic [gww_pkg::LW_BITS-1:0]     line_width_q;
	logic                            space_held_q, held_d;
	logic                            rel_busy_q;
	logic                            accept, ovf, is_nl, is_sp;
	gww_pkg::cmd_t                   cmd;

	// saturating offset add
	function automatic logic [gww_pkg::OFFSET_BITS-1:0] sat_add(
		input logic [gww_pkg::OFFSET_BITS-1:0] a,
		input logic [gww_pkg::ADV_BITS-1:0]    b
	);
		logic [gww_pkg::SUM_BITS-1:0] s;
		s = gww_pkg::SUM_BITS'(a) + gww_pkg::SUM_BITS'(b);
		return (s > gww_pkg::OFF_MAX) ? gww_pkg::OFFSET_BITS'(gww_pkg::OFF_MAX)
		                              : gww_pkg::OFFSET_BITS'(s);
	endfunction

	// hold off while the queue is full or a held word is still draining
	assign item_stall = q_full || rel_busy_q;
	assign accept     = item_valid && !item_stall;

	assign off_c = sat_add(line_offset_q, item.advance);
	assign ww_c  = sat_add(word_width_q, item.advance);
	assign ovf   = gww_pkg::CMP_BITS'(off_c) > gww_pkg::CMP_BITS'(line_width_q);
	assign is_nl = item.code_point == gww_pkg::CH_NEWLINE;
	assign is_sp = item.code_point == gww_pkg::CH_SPACE;

	// classify the character and plan its emissions
	always_comb begin
		cmd      = '0;
		wr       = '0;
		wr.addr  = word_count_q;
		wr.data  = item.code_point;
		offset_d = line_offset_q;
		width_d  = word_width_q;
		held_d   = space_held_q;
		count_d  = word_count_q;
		cmd.tail_cp = item.code_point;

		priority if (is_nl) begin
			// release held space and word, then the newline
			cmd.sp_en    = space_held_q;
			cmd.word_cnt = word_count_q;
			cmd.tail_en  = 1'b1;
			offset_d     = '0;
			width_d      = '0;
			held_d       = 1'b0;
			count_d      = '0;
		end else if (is_sp) begin
			cmd.sp_en    = space_held_q;
			cmd.word_cnt = word_count_q;
			width_d      = '0;
			count_d      = '0;
			if (ovf) begin
				// space that overflows turns into a newline
				cmd.tail_en = 1'b1;
				cmd.tail_cp = gww_pkg::CH_NEWLINE;
				offset_d    = '0;
				held_d      = 1'b0;
			end else begin
				offset_d = off_c;
				held_d   = 1'b1;
			end
		end else if (!space_held_q) begin
			cmd.tail_en = 1'b1;
			offset_d    = off_c;
		end else if (ovf) begin
			// held space breaks the line; word moves down
			cmd.sp_en    = 1'b1;
			cmd.sp_nl    = 1'b1;
			cmd.word_cnt = word_count_q;
			cmd.tail_en  = 1'b1;
			offset_d     = ww_c;
			width_d      = '0;
			held_d       = 1'b0;
			count_d      = '0;
		end else if (word_count_q >= gww_pkg::CNT_BITS'(gww_pkg::WORD_DEPTH)) begin
			// word store full: commit the held space as is
			cmd.sp_en    = 1'b1;
			cmd.word_cnt = word_count_q;
			cmd.tail_en  = 1'b1;
			cmd.forced   = 1'b1;
			offset_d     = off_c;
			width_d      = '0;
			held_d       = 1'b0;
			count_d      = '0;
		end else begin
			// append to the held word
			wr.en    = accept;
			width_d  = ww_c;
			offset_d = off_c;
			count_d  = gww_pkg::CNT_BITS'(word_count_q + 1'b1);
		end

		// end of text flushes whatever is still held
		if (item.end_of_text) begin
			if (held_d && count_d != '0) begin
				cmd.sp_en    = 1'b1;
				cmd.sp_nl    = 1'b0;
				cmd.word_cnt = count_d;
			end else if (held_d) begin
				cmd.post_en = 1'b1;
			end
			offset_d = '0;
			width_d  = '0;
			held_d   = 1'b0;
			count_d  = '0;
		end
	end

	assign q_cmd  = cmd;
	assign q_push = accept && (cmd.sp_en || cmd.word_cnt != '0 || cmd.tail_en || cmd.post_en);

	// wrap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_offset_q <= '0;
			word_width_q  <= '0;
			space_held_q  <= 1'b0;
			word_count_q  <= '0;
		end else if (accept) begin
			line_offset_q <= offset_d;
			word_width_q  <= width_d;
			space_held_q  <= held_d;
			word_count_q  <= count_d;
		end
	end

	// line width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= '0;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	// word release in flight: store must not be rewritten until it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_busy_q <= 1'b0;
		end else if (q_push && cmd.word_cnt != '0) begin
			rel_busy_q <= 1'b1;
		end else if (stat.word_done) begin
			rel_busy_q <= 1'b0;
		end
	end

endmodule

>>> sv/gww_queue.sv
// short command queue between the front and back parts
// depends on gww_pkg
module gww_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gww_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output gww_pkg::cmd_t pop_cmd,
	output logic          empty
);

	gww_pkg::cmd_t                 slot_q [gww_pkg::QDEPTH];
	logic [gww_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [gww_pkg::QCNT_BITS-1:0] cnt_q;

	assign full    = cnt_q == gww_pkg::QCNT_BITS'(gww_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == gww_pkg::QPTR_BITS'(gww_pkg::QDEPTH - 1)) ? '0
				            : gww_pkg::QPTR_BITS'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == gww_pkg::QPTR_BITS'(gww_pkg::QDEPTH - 1)) ? '0
				            : gww_pkg::QPTR_BITS'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= gww_pkg::QCNT_BITS'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= gww_pkg::QCNT_BITS'(cnt_q - 1'b1);
			end
		end
	end

endmodule

>>> sv/gww_back.sv
// back part: word store and the sequencer that turns commands into result transfers
// depends on gww_pkg
module gww_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  gww_pkg::cmd_t      q_cmd,
	output logic               q_pop,
	input  gww_pkg::wr_t       wr,
	output gww_pkg::bk_stat_t  stat,
	output logic               res_valid,
	input  logic               res_stall,
	output gww_pkg::result_t   res
);

	logic [gww_pkg::CP_BITS-1:0]  word_mem [gww_pkg::WORD_DEPTH];
	logic [gww_pkg::CP_BITS-1:0]  rd_data_q, emit_cp;
	logic [gww_pkg::CNT_BITS-1:0] idx_q, idx_d;
	gww_pkg::ph_t                 ph_q, ph_d;
	gww_pkg::cmd_t                cmd_q, cmd_d;
	gww_pkg::result_t             res_q;
	logic                         out_valid_q, emit_ok, emit, word_done;

	// phase that follows the current one for this command
	function automatic gww_pkg::ph_t next_ph(input gww_pkg::cmd_t c, input gww_pkg::ph_t cur);
		logic sp_ok, wd_ok, tl_ok, po_ok;
		gww_pkg::ph_t n;
		sp_ok = c.sp_en && cur == gww_pkg::PH_IDLE;
		wd_ok = c.word_cnt != '0 && (cur == gww_pkg::PH_IDLE || cur == gww_pkg::PH_SPACE);
		tl_ok = c.tail_en && cur != gww_pkg::PH_TAIL && cur != gww_pkg::PH_POST;
		po_ok = c.post_en && cur != gww_pkg::PH_POST;
		priority if (sp_ok) n = gww_pkg::PH_SPACE;
		else if (wd_ok)     n = gww_pkg::PH_WORD;
		else if (tl_ok)     n = gww_pkg::PH_TAIL;
		else if (po_ok)     n = gww_pkg::PH_POST;
		else                n = gww_pkg::PH_IDLE;
		return n;
	endfunction

	// result register frees up when empty or being taken
	assign emit_ok = !out_valid_q || !res_stall;

	// sequencer next state and outputs
	always_comb begin
		ph_d      = ph_q;
		cmd_d     = cmd_q;
		idx_d     = idx_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_cp   = gww_pkg::CH_SPACE;
		word_done = 1'b0;
		unique case (ph_q)
			gww_pkg::PH_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					cmd_d = q_cmd;
					ph_d  = next_ph(q_cmd, gww_pkg::PH_IDLE);
				end
			end
			gww_pkg::PH_SPACE: begin
				if (emit_ok) begin
					emit    = 1'b1;
					emit_cp = cmd_q.sp_nl ? gww_pkg::CH_NEWLINE : gww_pkg::CH_SPACE;
					ph_d    = next_ph(cmd_q, gww_pkg::PH_SPACE);
				end
			end
			gww_pkg::PH_WORD: begin
				if (emit_ok) begin
					emit    = 1'b1;
					emit_cp = rd_data_q;
					if (idx_q == gww_pkg::CNT_BITS'(cmd_q.word_cnt - 1'b1)) begin
						idx_d     = '0;
						word_done = 1'b1;
						ph_d      = next_ph(cmd_q, gww_pkg::PH_WORD);
					end else begin
						idx_d = gww_pkg::CNT_BITS'(idx_q + 1'b1);
					end
				end
			end
			gww_pkg::PH_TAIL: begin
				if (emit_ok) begin
					emit    = 1'b1;
					emit_cp = cmd_q.tail_cp;
					ph_d    = next_ph(cmd_q, gww_pkg::PH_TAIL);
				end
			end
			gww_pkg::PH_POST: begin
				if (emit_ok) begin
					emit    = 1'b1;
					emit_cp = gww_pkg::CH_SPACE;
					ph_d    = gww_pkg::PH_IDLE;
				end
			end
			default: begin
				ph_d = gww_pkg::PH_IDLE;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= gww_pkg::PH_IDLE;
			idx_q <= '0;
		end else begin
			ph_q  <= ph_d;
			idx_q <= idx_d;
		end
	end

	// current command
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
	end

	// word store: written by the front, read one entry ahead of the sequencer
	always_ff @(posedge clk) begin
		if (wr.en) begin
			word_mem[wr.addr] <= wr.data;
		end
		rd_data_q <= word_mem[idx_d];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_code_point <= emit_cp;
			res_q.run_last       <= ph_d == gww_pkg::PH_IDLE;
			res_q.word_too_long  <= cmd_q.forced;
		end
	end

	assign res_valid      = out_valid_q;
	assign res            = res_q;
	assign stat.word_act  = ph_q == gww_pkg::PH_WORD;
	assign stat.word_done = word_done;

endmodule

>>> sv/greedy_word_wrap.sv
// greedy word wrap top level: front, command queue and back
// depends on gww_pkg, gww_front, gww_queue, gww_back
//
// Streams characters with their glyph advances and emits them with spaces turned into
// newlines where a line would run past line_width (1/16 px). A character that goes out
// directly passes through the front and the queue, then the back sequencer, which
// writes one result into the output register per cycle unless res_stall holds it. When
// a step releases a held word, the front takes no further item until the last character
// of that word has left the word store, since the store has a single write port shared
// with the next word. Characters that only join the held word are taken at one per cycle
// while the queue is not full and no word drains. There is no clearing pass after reset.
module greedy_word_wrap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gww_pkg::LW_BITS-1:0] cfg_wr_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  gww_pkg::item_t              item,
	output logic                        res_valid,
	input  logic                        res_stall,
	output gww_pkg::result_t            res
);

	gww_pkg::cmd_t     q_cmd_in, q_cmd_out;
	gww_pkg::wr_t      wr;
	gww_pkg::bk_stat_t stat;
	logic              q_push, q_pop, q_full, q_empty;

	// character classification and wrap state
	gww_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd_in),
		.wr          (wr),
		.stat        (stat)
	);

	// command queue
	gww_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_cmd_out),
		.empty    (q_empty)
	);

	// emission sequencer and word store
	gww_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd_out),
		.q_pop     (q_pop),
		.wr        (wr),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	// the word store is never rewritten while a word drains from it
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !stat.word_act)
		else $error("word store written during word release");

endmodule

>>> tb/gww_checker.sv
`timescale 1ns / 1ps
// checker for greedy_word_wrap: watches the config, item and result transfers,
// predicts the wrapped character stream and compares it; depends on gww_pkg
module gww_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gww_pkg::LW_BITS-1:0] cfg_wr_data,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  gww_pkg::item_t              item,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  gww_pkg::result_t            res,
	output int                          fail_count,
	output int                          owed_count
);

	localparam int OB = gww_pkg::OFFSET_BITS;
	localparam int MAX_PER_CHAR = 64;

	// predicted wrap state
	logic [gww_pkg::LW_BITS-1:0] wrap_width;
	logic [OB-1:0]               line_pos;
	logic [OB-1:0]               held_width;
	logic                        space_pending;
	logic [gww_pkg::CP_BITS-1:0] held_word [gww_pkg::WORD_DEPTH];
	int                          held_len;

	// characters released by one item, and results still owed by the block
	logic [gww_pkg::CP_BITS-1:0] step_chars [$];
	gww_pkg::result_t            owed_chars [$];
	int                          errs;

	task automatic report_mismatch(input string msg);
		if (errs < 50)
			$display("%0t ns: mismatch: %s", $time, msg);
		errs++;
	endtask

	function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
			input logic [gww_pkg::ADV_BITS-1:0] b);
		logic [gww_pkg::SUM_BITS-1:0] s;
		s = gww_pkg::SUM_BITS'(a) + gww_pkg::SUM_BITS'(b);
		if (s > gww_pkg::OFF_MAX)
			s = gww_pkg::OFF_MAX;
		return s[OB-1:0];
	endfunction

	// release the pending space (as the given char) and the held word
	task automatic flush_held(input logic [gww_pkg::CP_BITS-1:0] space_as);
		int i;
		if (space_pending)
			step_chars.push_back(space_as);
		for (i = 0; i < held_len; i++)
			step_chars.push_back(held_word[i]);
		space_pending = 1'b0;
		held_len = 0;
		held_width = '0;
	endtask

	// one accepted character: update the wrap state and queue its results
	task automatic wrap_char(input gww_pkg::item_t it);
		logic [OB-1:0]    next_pos;
		logic [OB-1:0]    word_w;
		logic             forced;
		gww_pkg::result_t r;
		int               n;
		int               k;
		step_chars.delete();
		forced = 1'b0;
		next_pos = sat_add(line_pos, it.advance);
		if (it.code_point == gww_pkg::CH_NEWLINE) begin
			flush_held(gww_pkg::CH_SPACE);
			step_chars.push_back(gww_pkg::CH_NEWLINE);
			line_pos = '0;
		end else if (it.code_point == gww_pkg::CH_SPACE) begin
			flush_held(gww_pkg::CH_SPACE);
			if (next_pos > wrap_width) begin
				step_chars.push_back(gww_pkg::CH_NEWLINE);
				line_pos = '0;
			end else begin
				line_pos = next_pos;
				space_pending = 1'b1;
			end
		end else if (!space_pending) begin
			step_chars.push_back(it.code_point);
			line_pos = next_pos;
		end else if (next_pos > wrap_width) begin
			// the held space becomes the line break
			word_w = held_width;
			flush_held(gww_pkg::CH_NEWLINE);
			step_chars.push_back(it.code_point);
			line_pos = sat_add(word_w, it.advance);
		end else if (held_len >= gww_pkg::WORD_DEPTH) begin
			// store full: held space goes out as a plain space
			flush_held(gww_pkg::CH_SPACE);
			step_chars.push_back(it.code_point);
			line_pos = next_pos;
			forced = 1'b1;
		end else begin
			held_word[held_len] = it.code_point;
			held_len++;
			held_width = sat_add(held_width, it.advance);
			line_pos = next_pos;
		end
		if (it.end_of_text) begin
			flush_held(gww_pkg::CH_SPACE);
			line_pos = '0;
		end
		n = (step_chars.size() > MAX_PER_CHAR) ? MAX_PER_CHAR : step_chars.size();
		for (k = 0; k < n; k++) begin
			r.out_code_point = step_chars[k];
			r.run_last = (k == n - 1);
			r.word_too_long = forced;
			owed_chars.push_back(r);
		end
	endtask

	// compare results first, then predict newly accepted characters
	always @(posedge clk or negedge arst_n) begin
		gww_pkg::result_t want;
		if (!arst_n) begin
			wrap_width = '0;
			line_pos = '0;
			held_width = '0;
			space_pending = 1'b0;
			held_len = 0;
			owed_chars.delete();
			errs = 0;
			fail_count <= 0;
			owed_count <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (owed_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected result cp=%0h",
						res.out_code_point));
				end else begin
					want = owed_chars.pop_front();
					if (res.out_code_point !== want.out_code_point)
						report_mismatch($sformatf("out_code_point %0h, want %0h",
							res.out_code_point, want.out_code_point));
					if (res.run_last !== want.run_last)
						report_mismatch($sformatf("run_last %0b, want %0b",
							res.run_last, want.run_last));
					if (res.word_too_long !== want.word_too_long)
						report_mismatch($sformatf("word_too_long %0b, want %0b",
							res.word_too_long, want.word_too_long));
				end
			end
			if (cfg_wr_en)
				wrap_width = cfg_wr_data;
			if (item_valid && !item_stall)
				wrap_char(item);
			fail_count <= errs;
			owed_count <= owed_chars.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for greedy_word_wrap: clock, reset, line width writes and text stimulus
// depends on gww_pkg, greedy_word_wrap and gww_checker
module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 20;
	localparam logic [gww_pkg::LW_BITS-1:0] WIDTH_MAX = '1;
	localparam int NL_CP = int'(gww_pkg::CH_NEWLINE);
	localparam int SP_CP = int'(gww_pkg::CH_SPACE);

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	logic [gww_pkg::LW_BITS-1:0] cfg_wr_data = '0;
	logic                        item_valid = 1'b0;
	logic                        item_stall;
	gww_pkg::item_t              item = '0;
	logic                        res_valid;
	logic                        res_stall = 1'b0;
	gww_pkg::result_t            res;

	int fail_count;
	int owed_count;
	int items_sent = 0;
	int cycles = 0;
	bit idle_on = 1'b1;

	greedy_word_wrap uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	gww_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.fail_count (fail_count),
		.owed_count (owed_count)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// random result stall
	always @(posedge clk) begin
		res_stall <= idle_on && ($urandom_range(99) < 34);
	end

	// one character transfer, with a random gap before it
	task automatic send_item(input gww_pkg::item_t it);
		if (idle_on && $urandom_range(99) < 34) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while (idle_on && $urandom_range(99) < 34)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_char(input int cp, input int adv, input bit eot);
		gww_pkg::item_t it;
		it.code_point = gww_pkg::CP_BITS'(cp);
		it.advance = gww_pkg::ADV_BITS'(adv);
		it.end_of_text = eot;
		send_item(it);
	endtask

	// wait until every owed result is out, then let the block settle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_width(input logic [gww_pkg::LW_BITS-1:0] w);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// words after a space, plus newlines, end of text and random noise
	task automatic feed_text(input int n, input int adv_lo, input int adv_hi,
			input bit breaks);
		int stop;
		int len;
		int i;
		int cp;
		int r;
		gww_pkg::item_t it;
		stop = items_sent + n;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 12) begin
				it.code_point = gww_pkg::CP_BITS'($urandom);
				it.advance = gww_pkg::ADV_BITS'($urandom);
				it.end_of_text = breaks && ($urandom_range(7) == 0);
				send_item(it);
			end else if (r < 18 && breaks) begin
				send_char(NL_CP, $urandom_range(adv_hi, adv_lo),
					$urandom_range(9) == 0);
			end else begin
				send_char(SP_CP, $urandom_range(adv_hi, adv_lo), 1'b0);
				len = ($urandom_range(19) == 0) ? $urandom_range(66, 60) :
					$urandom_range(8, 1);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(9) == 0) begin
						cp = $urandom_range(32'h1FFFFF, 0);
						if (cp == NL_CP || cp == SP_CP)
							cp = 33;
					end else begin
						cp = $urandom_range(126, 33);
					end
					// long words use tiny advances so the store can fill up
					send_char(cp, (len > 8) ? $urandom_range(3, 0) :
						$urandom_range(adv_hi, adv_lo),
						breaks && i == len - 1 && $urandom_range(9) == 0);
				end
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: breaks, held words, newline and end of text handling
		set_width(gww_pkg::LW_BITS'(200));
		send_char(65, 0, 1'b0);
		send_char(SP_CP, 16, 1'b0);
		send_char(98, 16, 1'b0);
		send_char(99, 4095, 1'b0);
		send_char(SP_CP, 0, 1'b0);
		send_char(32'h1FFFFF, 10, 1'b0);
		send_char(SP_CP, 10, 1'b0);
		send_char(120, 5, 1'b0);
		send_char(NL_CP, 7, 1'b0);
		send_char(SP_CP, 5, 1'b0);
		send_char(121, 5, 1'b0);
		send_char(122, 5, 1'b1);
		send_char(0, 0, 1'b1);
		send_char(SP_CP, 4095, 1'b0);
		send_char(SP_CP, 0, 1'b0);
		send_char(SP_CP, 300, 1'b0);
		send_char(113, 4095, 1'b1);
		send_char(SP_CP, 8, 1'b1);
		send_char(NL_CP, 4095, 1'b1);
		send_char(32'h10FFFF, 4095, 1'b0);
		drain();

		// zero width: a held space breaks unless the next advance is zero
		set_width(gww_pkg::LW_BITS'(0));
		feed_text(30, 0, 60, 1'b1);
		drain();

		// moderate width with frequent breaks
		set_width(gww_pkg::LW_BITS'(1200));
		feed_text(60, 0, 120, 1'b1);
		drain();

		// widest line, no breaks; first stretch runs without idling
		set_width(WIDTH_MAX);
		idle_on = 1'b0;
		feed_text(100, 3000, 4095, 1'b0);
		idle_on = 1'b1;
		feed_text(130, 3000, 4095, 1'b0);
		send_char(NL_CP, 0, 1'b1);
		drain();

		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
